[rtl/sefc_pkg.sv]
`default_nettype none

package sefc_pkg;

   localparam int CMP_WIDTH = 10;

   localparam logic [7:0] LEN_OVERHEAD   = 8'h05;
   localparam logic [7:0] PAYLOAD_OFFSET = 8'h02;
   localparam int         STATUS_INDEX   = 3;
   localparam int         PAYLOAD_FIRST  = 4;
   localparam int         MIN_FRAME      = 6;
   localparam int         LENGTH_INDEX   = 2;

   localparam logic [7:0] START_BYTE_RESET = 8'h02;
   localparam logic [7:0] END_BYTE_RESET   = 8'h03;

   localparam logic REG_START_BYTE = 1'b0;
   localparam logic REG_END_BYTE   = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_OK       = 2'd0,
      VERDICT_FORMAT   = 2'd1,
      VERDICT_CHECKSUM = 2'd2
   } verdict_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] end_byte;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        is_status;
      logic        is_payload;
      logic        frame_done;
      verdict_type verdict;
   } rsp_word_type;

endpackage

`default_nettype wire

[rtl/stx_etx_frame_checker.sv]
`default_nettype none

// Receive-side checker for start/end delimited reply frames with an XOR check
// byte. Each byte on req_ comes out once on rsp_ in the cycle after it is accepted,
// tagged as status or payload; the word with tlast carries the frame verdict in
// tuser. One byte per clock cycle is sustained: the per-byte position counter and
// XOR accumulator update on each accepted byte, and one result register parts the
// two sides, so req_tready stays high unless a result waits on a stalled rsp_.
// Delimiter values are set through the csr_ port (start byte at 0x0, end byte
// at 0x4); frames longer than MAX_FRAME bytes end as format errors.
module stx_etx_frame_checker #(
   parameter int MAX_FRAME = 263
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  wire logic        req_tlast,    // block_end

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,    // [7:0] data_byte
   output logic      [3:0]  rsp_tuser,    // [0] is_status, [1] is_payload, [3:2] verdict
   output logic             rsp_tlast,    // frame_done

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   sefc_pkg::cfg_type      cfg;
   sefc_pkg::rsp_word_type word;
   sefc_pkg::rsp_word_type rsp_word;
   logic                   can_load;
   logic                   accept;

   assign req_tready = can_load;
   assign accept     = req_tvalid && req_tready;

   sefc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sefc_frame_track #(
      .MAX_FRAME (MAX_FRAME)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_tdata),
      .block_end (req_tlast),
      .cfg       (cfg),
      .word      (word)
   );

   sefc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .word       (word),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .can_load   (can_load),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = rsp_word.data_byte;
   assign rsp_tuser = {rsp_word.verdict, rsp_word.is_payload, rsp_word.is_status};
   assign rsp_tlast = rsp_word.frame_done;

endmodule

`default_nettype wire

[rtl/sefc_csr.sv]
`default_nettype none

module sefc_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output sefc_pkg::cfg_type     cfg
);

   logic [7:0] start_byte_ff;
   logic [7:0] end_byte_ff;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= sefc_pkg::START_BYTE_RESET;
         end_byte_ff   <= sefc_pkg::END_BYTE_RESET;
      end else if (wr_en) begin
         if (csr_paddr[2] == sefc_pkg::REG_START_BYTE) begin
            start_byte_ff <= csr_pwdata[7:0];
         end else begin
            end_byte_ff <= csr_pwdata[7:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == sefc_pkg::REG_START_BYTE) begin
         csr_prdata = {24'd0, start_byte_ff};
      end else begin
         csr_prdata = {24'd0, end_byte_ff};
      end
   end

   assign cfg.start_byte = start_byte_ff;
   assign cfg.end_byte   = end_byte_ff;

endmodule

`default_nettype wire

[rtl/sefc_frame_track.sv]
`default_nettype none

module sefc_frame_track #(
   parameter int MAX_FRAME = 263
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         rx_byte,
   input  wire logic               block_end,
   input  wire sefc_pkg::cfg_type  cfg,
   output sefc_pkg::rsp_word_type  word
);

   localparam int PosWidth = $clog2(MAX_FRAME + 1);
   localparam int CmpW     = sefc_pkg::CMP_WIDTH;

   logic [PosWidth-1:0] pos_ff,   pos_in;
   logic [7:0]          xor_ff,   xor_in;
   logic [7:0]          len_ff,   len_in;
   logic                start_ok_ff, start_ok_in;
   logic [7:0]          prev_ff,  prev_in;

   logic            over;
   logic [CmpW-1:0] idx_w;
   logic [CmpW-1:0] frame_len;
   logic [CmpW-1:0] payload_last;
   logic [CmpW-1:0] expect_len;
   logic            fmt_err;
   logic            sum_err;

   assign over         = pos_ff >= PosWidth'(MAX_FRAME);
   assign idx_w        = CmpW'(pos_ff);
   assign frame_len    = idx_w + CmpW'(1);
   assign payload_last = CmpW'(len_ff) + CmpW'(sefc_pkg::PAYLOAD_OFFSET);
   assign expect_len   = CmpW'(len_ff) + CmpW'(sefc_pkg::LEN_OVERHEAD);

   assign fmt_err = over || (frame_len < CmpW'(sefc_pkg::MIN_FRAME)) || !start_ok_ff ||
                    (rx_byte != cfg.end_byte) || (expect_len != frame_len);
   assign sum_err = (xor_ff ^ prev_ff) != prev_ff;

   always_comb begin
      word.data_byte  = rx_byte;
      word.is_status  = !over && (pos_ff == PosWidth'(sefc_pkg::STATUS_INDEX));
      word.is_payload = !over && (idx_w >= CmpW'(sefc_pkg::PAYLOAD_FIRST)) &&
                        (idx_w <= payload_last);
      word.frame_done = block_end;
      if (!block_end) begin
         word.verdict = sefc_pkg::VERDICT_OK;
      end else if (fmt_err) begin
         word.verdict = sefc_pkg::VERDICT_FORMAT;
      end else if (sum_err) begin
         word.verdict = sefc_pkg::VERDICT_CHECKSUM;
      end else begin
         word.verdict = sefc_pkg::VERDICT_OK;
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      len_in      = len_ff;
      start_ok_in = start_ok_ff;
      prev_in     = prev_ff;
      if (block_end) begin
         pos_in      = '0;
         xor_in      = '0;
         len_in      = '0;
         start_ok_in = 1'b0;
         prev_in     = '0;
      end else begin
         if (pos_ff == '0) begin
            start_ok_in = rx_byte == cfg.start_byte;
         end else begin
            xor_in = xor_ff ^ rx_byte;
         end
         if (pos_ff == PosWidth'(sefc_pkg::LENGTH_INDEX)) begin
            len_in = rx_byte;
         end
         prev_in = rx_byte;
         if (!over) begin
            pos_in = pos_ff + PosWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         xor_ff      <= '0;
         len_ff      <= '0;
         start_ok_ff <= 1'b0;
         prev_ff     <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         xor_ff      <= xor_in;
         len_ff      <= len_in;
         start_ok_ff <= start_ok_in;
         prev_ff     <= prev_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && block_end |=> pos_ff == '0 && xor_ff == '0 && !start_ok_ff)
      else $error("frame state not cleared after final word");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosWidth'(MAX_FRAME))
      else $error("byte position past saturation");

   a_hold_when_over: assert property (@(posedge clock) disable iff (reset)
      accept && !block_end && over |=> pos_ff == $past(pos_ff))
      else $error("byte position moved while saturated");

   a_verdict_only_last: assert property (@(posedge clock) disable iff (reset)
      !block_end |-> word.verdict == sefc_pkg::VERDICT_OK)
      else $error("verdict given on a word that is not final");

endmodule

`default_nettype wire

[rtl/sefc_out_reg.sv]
`default_nettype none

module sefc_out_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire sefc_pkg::rsp_word_type word,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tvalid,
   output logic                        can_load,
   output sefc_pkg::rsp_word_type      rsp_word
);

   logic                   valid_ff;
   sefc_pkg::rsp_word_type word_ff;

   assign can_load   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_word   = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_tready |=> valid_ff && word_ff == $past(word_ff))
      else $error("pending result word overwritten");

   a_load_gated: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("word loaded while output stalled");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded word not presented");

endmodule

`default_nettype wire
